### hw/rtl/bfd_pkg.sv
// shared types and constants of the box filter downscaler
package bfd_pkg;

    localparam int LANES      = 4;
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 32;
    localparam int LANE_W     = 14;
    localparam int ACC_W      = 20;
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 13;
    localparam int CNT_W      = 17;
    localparam int SIZE_W     = 13;
    localparam int BLK_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int QUOT_W     = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_BLOCK_SIZE = 2'd2
    } bfd_reg_t;

    // one finished block row segment handed from front to back
    typedef struct packed {
        logic [LANES-1:0][LANE_W-1:0] sums;
        logic [IDX_W-1:0]             acc_idx;
        logic                         first_row;
        logic                         last_row;
        logic [CNT_W-1:0]             cnt;
        logic [COORD_W-1:0]           ox;
        logic [COORD_W-1:0]           oy;
        logic                         frame_last;
    } bfd_op_t;

    // queue status seen by front, back and top
    typedef struct packed {
        logic full;
        logic nonempty;
    } bfd_qstat_t;

endpackage

### hw/rtl/bfd_front.sv
// front part: config registers, raster position, horizontal run sums
module bfd_front
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_BLOCK  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  bfd_qstat_t            qstat,
    output logic                  push,
    output bfd_op_t               push_op
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int NW  = $clog2(MAX_BLOCK + 1);
    localparam int CW  = $clog2(MAX_BLOCK);
    localparam int XEW = ((WW > NW) ? WW : NW) + 2;
    localparam int YEW = ((HW > NW) ? HW : NW) + 2;

    logic [SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [BLK_W-1:0]  block_size_reg;
    logic [CW-1:0]     cx_reg, cy_reg;
    logic [XW-1:0]     x0_reg, bx_reg;
    logic [YW-1:0]     y0_reg, by_reg;
    logic [LANES-1:0][LANE_W-1:0] run_reg, run_next;

    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic [NW-1:0]  n, ex, ey;
    logic [XEW-1:0] rem_x;
    logic [YEW-1:0] rem_y;
    logic col_kept, row_kept, col_last, row_last, col_end, row_wrap, frame_wrap;
    logic accept, cfg_hit;

    // clamped frame and block sizes
    always_comb
    begin
        if (src_width_reg == '0)
            w = WW'(1);
        else if (32'(src_width_reg) > 32'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(src_width_reg);
        if (src_height_reg == '0)
            h = HW'(1);
        else if (32'(src_height_reg) > 32'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(src_height_reg);
        if (block_size_reg == '0)
            n = NW'(1);
        else if (32'(block_size_reg) > 32'(MAX_BLOCK))
            n = NW'(MAX_BLOCK);
        else
            n = NW'(block_size_reg);
    end

    // extent of the current block, kept and last-block tests
    always_comb
    begin
        rem_x    = XEW'(w) - XEW'(x0_reg);
        rem_y    = YEW'(h) - YEW'(y0_reg);
        ex       = (rem_x > XEW'(n)) ? n : NW'(rem_x);
        ey       = (rem_y > YEW'(n)) ? n : NW'(rem_y);
        col_kept = (bx_reg == '0) || ((XEW'(ex) << 1) >= XEW'(n));
        row_kept = (by_reg == '0) || ((YEW'(ey) << 1) >= YEW'(n));
        col_last = (rem_x << 1) < (XEW'(n) + (XEW'(n) << 1));
        row_last = (rem_y << 1) < (YEW'(n) + (YEW'(n) << 1));
        col_end  = (NW'(cx_reg) + NW'(1)) == ex;
        row_wrap = (XEW'(x0_reg) + XEW'(cx_reg) + XEW'(1)) >= XEW'(w);
        frame_wrap = (YEW'(y0_reg) + YEW'(cy_reg) + YEW'(1)) >= YEW'(h);
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = qstat.full;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        unique case (cfg_index)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_BLOCK_SIZE: cfg_hit = cfg_valid;
            default:                                        cfg_hit = 1'b0;
        endcase
    end

    // run sums of the current block row
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            run_next[k] = ((cx_reg == '0) ? '0 : run_reg[k])
                        + LANE_W'(pixel[k*BYTE_W +: BYTE_W]);
        end
    end

    // block op leaving at the last column of a kept block
    always_comb
    begin
        push               = accept && col_kept && row_kept && col_end;
        push_op.sums       = run_next;
        push_op.acc_idx    = IDX_W'(bx_reg);
        push_op.first_row  = (cy_reg == '0);
        push_op.last_row   = (NW'(cy_reg) + NW'(1)) == ey;
        push_op.cnt        = CNT_W'(ex) * CNT_W'(ey);
        push_op.ox         = COORD_W'(bx_reg);
        push_op.oy         = COORD_W'(by_reg);
        push_op.frame_last = col_last && row_last;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SIZE_W'(4096);
            src_height_reg <= SIZE_W'(4096);
            block_size_reg <= BLK_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_BLOCK_SIZE: block_size_reg <= cfg_data[BLK_W-1:0];
                default:        ;
            endcase
        end
    end

    // raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0; x0_reg <= '0; bx_reg <= '0;
            cy_reg <= '0; y0_reg <= '0; by_reg <= '0;
            run_reg <= '0;
        end
        else if (cfg_hit)
        begin
            cx_reg <= '0; x0_reg <= '0; bx_reg <= '0;
            cy_reg <= '0; y0_reg <= '0; by_reg <= '0;
            run_reg <= '0;
        end
        else if (accept)
        begin
            if (col_kept && row_kept)
                run_reg <= run_next;
            if (row_wrap)
            begin
                cx_reg <= '0; x0_reg <= '0; bx_reg <= '0;
                if (frame_wrap)
                begin
                    cy_reg <= '0; y0_reg <= '0; by_reg <= '0;
                end
                else if ((NW'(cy_reg) + NW'(1)) == n)
                begin
                    cy_reg <= '0;
                    y0_reg <= y0_reg + YW'(n);
                    by_reg <= by_reg + YW'(1);
                end
                else
                    cy_reg <= cy_reg + CW'(1);
            end
            else if ((NW'(cx_reg) + NW'(1)) == n)
            begin
                cx_reg <= '0;
                x0_reg <= x0_reg + XW'(n);
                bx_reg <= bx_reg + XW'(1);
            end
            else
                cx_reg <= cx_reg + CW'(1);
        end
    end

endmodule

### hw/rtl/bfd_queue.sv
// short op queue between front and back
module bfd_queue
    import bfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bfd_op_t    push_op,
    input  logic       pop,
    output bfd_op_t    pop_op,
    output bfd_qstat_t qstat
);

    bfd_op_t            slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign pop_op         = slot_reg[rd_ptr_reg];
    assign qstat.full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign qstat.nonempty = (count_reg != '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
        end
    end

endmodule

### hw/rtl/bfd_back.sv
// back part: column accumulators, pipelined divider, output register
module bfd_back
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfd_qstat_t         qstat,
    input  bfd_op_t            q_op,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   out_pixel,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic               frame_last
);

    localparam int ACC_DEPTH = MAX_WIDTH / 2;
    localparam int AW        = $clog2(ACC_DEPTH);
    localparam int CMPW      = CNT_W + QUOT_W + 1;

    typedef logic [LANES-1:0][ACC_W-1:0]  acc_word_t;
    typedef logic [LANES-1:0][QUOT_W-1:0] quot_t;

    acc_word_t acc_mem [ACC_DEPTH];

    logic      adv;
    logic      b_valid_reg, byp_hit_reg;
    bfd_op_t   b_op_reg;
    acc_word_t mem_rd_reg, byp_data_reg, acc_old, tot;
    logic      b_wr;

    logic               dv_valid_reg [QUOT_W+1];
    acc_word_t          dv_rem_reg   [QUOT_W+1];
    quot_t              dv_q_reg     [QUOT_W+1];
    logic [CNT_W-1:0]   dv_cnt_reg   [QUOT_W+1];
    logic [COORD_W-1:0] dv_x_reg     [QUOT_W+1];
    logic [COORD_W-1:0] dv_y_reg     [QUOT_W+1];
    logic               dv_fl_reg    [QUOT_W+1];
    acc_word_t          dv_rem_next  [QUOT_W+1];
    quot_t              dv_q_next    [QUOT_W+1];

    logic               out_valid_reg, frame_last_reg;
    logic [PIX_W-1:0]   out_pixel_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;

    // whole back pipeline moves when the output register can take a result
    assign adv  = !out_valid_reg || !out_stall;
    assign pop  = adv && qstat.nonempty;

    // column total: run sums plus accumulated rows above
    always_comb
    begin
        acc_old = byp_hit_reg ? byp_data_reg : mem_rd_reg;
        for (int k = 0; k < LANES; k++)
        begin
            tot[k] = ACC_W'(b_op_reg.sums[k]);
            if (!b_op_reg.first_row)
                tot[k] = tot[k] + acc_old[k];
        end
        b_wr = b_valid_reg && !b_op_reg.last_row;
    end

    // accumulator memory with same-cycle write bypass
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_wr)
                acc_mem[b_op_reg.acc_idx[AW-1:0]] <= tot;
            if (pop)
                mem_rd_reg <= acc_mem[q_op.acc_idx[AW-1:0]];
            byp_data_reg <= tot;
            if (pop)
                b_op_reg <= q_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= pop;
            byp_hit_reg <= b_wr && (b_op_reg.acc_idx[AW-1:0] == q_op.acc_idx[AW-1:0]);
        end
    end

    // divider entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= b_valid_reg && b_op_reg.last_row;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_rem_reg[0] <= tot;
            dv_q_reg[0]   <= '0;
            dv_cnt_reg[0] <= b_op_reg.cnt;
            dv_x_reg[0]   <= b_op_reg.ox;
            dv_y_reg[0]   <= b_op_reg.oy;
            dv_fl_reg[0]  <= b_op_reg.frame_last;
        end
    end

    assign dv_rem_next[0] = dv_rem_reg[0];
    assign dv_q_next[0]   = dv_q_reg[0];

    // restoring division, one quotient bit per stage
    for (genvar s = 1; s <= QUOT_W; s++)
    begin : g_div
        always_comb
        begin
            logic [CMPW-1:0] shifted;
            shifted = CMPW'(dv_cnt_reg[s-1]) << (QUOT_W - s);
            for (int k = 0; k < LANES; k++)
            begin
                dv_rem_next[s][k] = dv_rem_reg[s-1][k];
                dv_q_next[s][k]   = dv_q_reg[s-1][k];
                if (CMPW'(dv_rem_reg[s-1][k]) >= shifted)
                begin
                    dv_rem_next[s][k] = dv_rem_reg[s-1][k] - shifted[ACC_W-1:0];
                    dv_q_next[s][k][QUOT_W-s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[s] <= 1'b0;
            else if (adv)
                dv_valid_reg[s] <= dv_valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[s] <= dv_rem_next[s];
                dv_q_reg[s]   <= dv_q_next[s];
                dv_cnt_reg[s] <= dv_cnt_reg[s-1];
                dv_x_reg[s]   <= dv_x_reg[s-1];
                dv_y_reg[s]   <= dv_y_reg[s-1];
                dv_fl_reg[s]  <= dv_fl_reg[s-1];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid_reg[QUOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pixel_reg  <= dv_q_reg[QUOT_W];
            out_x_reg      <= dv_x_reg[QUOT_W];
            out_y_reg      <= dv_y_reg[QUOT_W];
            frame_last_reg <= dv_fl_reg[QUOT_W];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign frame_last = frame_last_reg;

endmodule

### hw/rtl/box_filter_downscaler.sv
// top level of the box filter downscaler
//
// channel   direction  handshake             payload
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in         in_valid/in_stall     pixel
// out       out        out_valid/out_stall   out_pixel, out_x, out_y, frame_last
//
// the front takes one pixel per cycle while the queue is not full; each pixel
// that ends a kept block row sends one op through a four-entry queue to the
// back, which takes one op per cycle while out_stall is low (accumulator read,
// add, write with bypass) and then an 8-stage divider.
// after reset the accumulators hold no defined value; no clearing pass is run.
// in_stall rises only while the queue is full; out_stall freezes the back.
module box_filter_downscaler
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_BLOCK  = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      out_pixel,
    output logic [COORD_W-1:0]    out_x,
    output logic [COORD_W-1:0]    out_y,
    output logic                  frame_last
);

    bfd_qstat_t qstat;
    logic       q_push, q_pop;
    bfd_op_t    push_op, pop_op;

    // front part
    bfd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCK  (MAX_BLOCK)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .qstat     (qstat),
        .push      (q_push),
        .push_op   (push_op)
    );

    // op queue
    bfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .qstat   (qstat)
    );

    // back part
    bfd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .q_op       (pop_op),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pixel  (out_pixel),
        .out_x      (out_x),
        .out_y      (out_y),
        .frame_last (frame_last)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && qstat.full))
        else $error("op pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> qstat.nonempty)
        else $error("op popped from empty queue");

    // the pixel input is never stalled while the queue is not full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        (qstat.full && !q_pop) |=> qstat.full || !in_stall)
        else $error("queue state and input stall disagree");

endmodule
